@@ design/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, controller states and the command/status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Field widths
    localparam int MOD_BITS  = 31;
    localparam int EXP_BITS  = 63;
    localparam int BASE_BITS = 63;
    localparam int RES_BITS  = 31;

    // A full product of two residues
    localparam int PROD_BITS = 2 * MOD_BITS;

    // The remainder shifter takes either the base or a product as its dividend
    localparam int DIV_BITS  = (BASE_BITS > PROD_BITS) ? BASE_BITS : PROD_BITS;

    // Counter over the dividend bits, one bit per cycle
    localparam int CNT_BITS  = $clog2(DIV_BITS);

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_CHECK,
        ST_MULT,
        ST_REDUCE,
        ST_COMMIT,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new request
        logic mult;       // form both products
        logic step;       // one remainder step on both lanes
        logic take_base;  // reduced base becomes the running power
        logic commit;     // update accumulator, power and exponent
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic exp_zero;   // no exponent bits left to scan
    } t_dp_status;

endpackage

@@ design/mexp_if.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation channel interfaces
// Request, response and configuration write channels, each with valid and
// ready handshake signals and a source and sink modport.
// ----------------------------------------------------------------------------

// Request channel: one base and one exponent
interface mexp_req_if;
    import mexp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BASE_BITS-1:0] base_value;
    logic [EXP_BITS-1:0]  exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

// Response channel: one residue
interface mexp_rsp_if;
    import mexp_pkg::*;

    logic                valid;
    logic                ready;
    logic [RES_BITS-1:0] residue;

    modport source (output valid, output residue, input ready);
    modport sink   (input valid, input residue, output ready);
endinterface

// Configuration write channel: the modulus register
interface mexp_cfg_if;
    import mexp_pkg::*;

    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink   (input valid, input modulus, output ready);
endinterface

@@ design/mexp_datapath.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the exponent, accumulator and running power, two 31 by 31 bit
// multipliers and two bit-serial remainder lanes. Lane 0 reduces the
// accumulator product, lane 1 reduces the base and then the square.
// ----------------------------------------------------------------------------
module mexp_datapath (
    input  logic                          i_clk,
    input  mexp_pkg::t_dp_cmd             i_cmd,
    input  logic [mexp_pkg::BASE_BITS-1:0] i_base,
    input  logic [mexp_pkg::EXP_BITS-1:0]  i_exp,
    input  logic [mexp_pkg::MOD_BITS-1:0]  i_modulus,
    output mexp_pkg::t_dp_status          o_status,
    output logic [mexp_pkg::RES_BITS-1:0]  o_residue
);
    import mexp_pkg::*;

    logic [EXP_BITS-1:0]  r_exp;
    logic [MOD_BITS-1:0]  r_acc;
    logic [MOD_BITS-1:0]  r_pow;
    logic [DIV_BITS-1:0]  r_div [2];
    logic [MOD_BITS-1:0]  r_rem [2];

    logic [MOD_BITS-1:0]  n_rem [2];
    logic [PROD_BITS-1:0] w_prod_acc;
    logic [PROD_BITS-1:0] w_prod_sq;
    logic [MOD_BITS:0]    w_trial [2];
    logic                 w_mod_one;

    // Products of the current accumulator and power
    assign w_prod_acc = PROD_BITS'(r_acc) * PROD_BITS'(r_pow);
    assign w_prod_sq  = PROD_BITS'(r_pow) * PROD_BITS'(r_pow);

    assign w_mod_one  = (i_modulus == MOD_BITS'(1));

    // One restoring remainder step per lane: shift in the next dividend bit,
    // subtract the modulus when it fits
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_trial[k] = {r_rem[k], r_div[k][DIV_BITS-1]};
            if (w_trial[k] >= {1'b0, i_modulus}) begin
                n_rem[k] = MOD_BITS'(w_trial[k] - {1'b0, i_modulus});
            end else begin
                n_rem[k] = w_trial[k][MOD_BITS-1:0];
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_exp    <= i_exp;
            r_acc    <= w_mod_one ? '0 : MOD_BITS'(1);
            r_div[1] <= DIV_BITS'(i_base);
            r_rem[0] <= '0;
            r_rem[1] <= '0;
        end
        if (i_cmd.mult) begin
            r_div[0] <= DIV_BITS'(w_prod_acc);
            r_div[1] <= DIV_BITS'(w_prod_sq);
            r_rem[0] <= '0;
            r_rem[1] <= '0;
        end
        if (i_cmd.step) begin
            r_div[0] <= {r_div[0][DIV_BITS-2:0], 1'b0};
            r_div[1] <= {r_div[1][DIV_BITS-2:0], 1'b0};
            r_rem[0] <= n_rem[0];
            r_rem[1] <= n_rem[1];
        end
        if (i_cmd.take_base) begin
            r_pow <= r_rem[1];
        end
        if (i_cmd.commit) begin
            if (r_exp[0]) begin
                r_acc <= r_rem[0];
            end
            r_pow <= r_rem[1];
            r_exp <= r_exp >> 1;
        end
    end

    // Status and result; a zero modulus answers zero
    assign o_status.exp_zero = (r_exp == '0);
    assign o_residue = (i_modulus == '0) ? '0 : RES_BITS'(r_acc);

endmodule

@@ design/mexp_controller.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences base reduction, then one multiply and reduce round per exponent
// bit until no set exponent bits remain, then hands the result over.
// ----------------------------------------------------------------------------
module mexp_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_out_free,
    input  mexp_pkg::t_dp_status i_status,
    output mexp_pkg::t_dp_cmd    o_cmd,
    output logic                 o_ready,
    output logic                 o_done
);
    import mexp_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0] n_cnt;
    logic                w_last;

    assign w_last = (r_cnt == CNT_BITS'(DIV_BITS - 1));

    // State and bit counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_BASE;
                end
            end
            ST_BASE: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (w_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // The first pass after base reduction picks up the power
                if (r_cnt == '0) begin
                    n_state = i_status.exp_zero ? ST_DONE : ST_MULT;
                end else begin
                    o_cmd.take_base = 1'b1;
                    n_cnt           = '0;
                end
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_cnt      = '0;
                n_state    = ST_REDUCE;
            end
            ST_REDUCE: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (w_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_cnt        = '0;
                n_state      = ST_CHECK;
            end
            ST_DONE: begin
                o_done = i_out_free;
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/modular_exponentiation.sv @@
// One multiply and reduce round runs per exponent bit up to the highest set
// bit, and none runs for a zero exponent. Each round is a multiply step, a
// pass through the bit-serial remainder lanes, and an update (commit and
// check). A new request is taken only once the previous one has finished.
// A request may be taken while a finished residue waits. Synchronous
// active-low reset sets the modulus to 1 and empties the output.
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Right-to-left square and multiply of a 63-bit base and exponent modulo a
// configured 31-bit modulus, with a modulus register and an output register.
// ----------------------------------------------------------------------------
module modular_exponentiation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mexp_req_if.sink    i_req,
    mexp_rsp_if.source  o_rsp,
    mexp_cfg_if.sink    i_cfg
);
    import mexp_pkg::*;

    logic [MOD_BITS-1:0] r_modulus;
    logic                r_out_valid;
    logic [RES_BITS-1:0] r_residue;

    t_dp_cmd             w_cmd;
    t_dp_status          w_status;
    logic                w_ready;
    logic                w_done;
    logic                w_out_free;
    logic [RES_BITS-1:0] w_residue;

    // Modulus register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_BITS'(1);
        end else if (i_cfg.valid) begin
            r_modulus <= i_cfg.modulus;
        end
    end

    // Output register
    assign w_out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_residue <= w_residue;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.residue = r_residue;
    assign i_req.ready   = w_ready;

    // Controller
    mexp_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_req.valid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_ready    (w_ready),
        .o_done     (w_done)
    );

    // Datapath
    mexp_datapath u_datapath (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_base    (i_req.base_value),
        .i_exp     (i_req.exponent),
        .i_modulus (r_modulus),
        .o_status  (w_status),
        .o_residue (w_residue)
    );

endmodule

@@ design/mexp_checker.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Watches the top-level ports: response stability, residue range against
// the written modulus, and the busy period after a request.
// ----------------------------------------------------------------------------
module mexp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [mexp_pkg::RES_BITS-1:0] i_rsp_residue,
    input logic                          i_cfg_valid,
    input logic                          i_cfg_ready,
    input logic [mexp_pkg::MOD_BITS-1:0] i_cfg_modulus
);
    import mexp_pkg::*;

    logic [MOD_BITS-1:0] r_mod;

    // Shadow copy of the modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_BITS'(1);
        end else if (i_cfg_valid && i_cfg_ready) begin
            r_mod <= i_cfg_modulus;
        end
    end

    // A stalled response holds its value
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_residue))
        else $error("response changed while stalled");

    // The residue lies below the modulus, or is zero for a zero modulus
    a_rsp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ((r_mod == '0) ? (i_rsp_residue == '0)
                                       : (i_rsp_residue < r_mod)))
        else $error("residue out of range");

    // After a request is taken, ready is checked to stay low at the start of the reduction of the base
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready ##1 !i_req_ready)
        else $error("request taken during computation");

    // The edge that takes a request never raises a new response
    a_rsp_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !$past(i_req_valid && i_req_ready))
        else $error("response appeared without computation");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_residue (o_rsp.residue),
    .i_cfg_valid   (i_cfg.valid),
    .i_cfg_ready   (i_cfg.ready),
    .i_cfg_modulus (i_cfg.modulus)
);
